>>> rtl/core/glwa_pkg.sv
// Shared types and constants of the GPU load window averager.
package glwa_pkg;

  // One input word: a load sample or a resume marker.
  typedef struct packed {
    logic        opcode;
    logic [63:0] timestamp_us;
    logic [63:0] busy_cycle_count;
    logic [31:0] counter_rate_hz;
    logic [31:0] frequency_hz;
  } in_t;

  // One result word: the current averaged window.
  typedef struct packed {
    logic [31:0] avg_busy_us;
    logic [31:0] avg_total_us;
    logic [31:0] avg_frequency_hz;
  } out_t;

  localparam logic        OP_SAMPLE     = 1'b0;
  localparam logic        OP_RESUME     = 1'b1;
  localparam logic [31:0] MAX32         = 32'hFFFF_FFFF;
  localparam logic [31:0] MICROS_PER_S  = 32'd1_000_000;
  localparam logic [9:0]  MICROS_PER_MS = 10'd1000;
  localparam logic [3:0]  HIST_NUM      = 4'd11;
  localparam logic [3:0]  HIST_DEN      = 4'd10;
  // Ceiling of 2^22 / 10; exact division by ten for dividends below 2^19.
  localparam logic [19:0] HIST_RECIP    = 20'd419431;
  localparam logic [13:0] POLL_RESET    = 14'd50;
  localparam int          DIV_STEPS     = 96;

endpackage

>>> rtl/core/gpu_load_window_averager.sv
// Load window averager: a sequencer around one multiplier and one bit-serial divider.
//
// Usage: load samples and resume markers enter on the in_ valid/ready channel as
// one word each. A load sample yields one result word on the out_ valid/ready
// channel; a resume marker resets the counter baseline and yields nothing.
// The polling period is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce it. A resume marker
// is absorbed while the sequencer stays idle. A load sample runs the shared restoring
// divider once when the sample replaces the average, twice when it merges, and three
// times when the window is also rescaled; the sequencer returns to idle as the result
// enters the output register. The divider retires one quotient bit per cycle over a
// 96-bit dividend; one item is in work at a time.
// in_ready is high only while the sequencer is idle.
// When the receiver stalls, a finished word waits in the output register and
// the sequencer holds before writing the next result, so nothing is lost.
// Reset (synchronous, rst_n low) clears the window, the baselines and the
// output valid, and sets the polling period to 50 ms.
module gpu_load_window_averager (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  glwa_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output glwa_pkg::out_t      out_data,
  input  logic                cfg_we,
  input  logic [13:0]         cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_BM0, S_BM1, S_BADD, S_DIV, S_DIVDONE, S_DECIDE,
    S_SM, S_SLOAD, S_FM0, S_FM1, S_FADD, S_PUSH
  } state_t;

  typedef enum logic [1:0] {
    D_BUSY, D_SCALE, D_FREQ
  } dop_t;

  state_t       state_r;
  dop_t         dop_r;
  logic [13:0]  poll_r;
  logic [63:0]  last_busy_r;
  logic [63:0]  last_time_r;
  logic [31:0]  wb_r;
  logic [31:0]  wt_r;
  logic [31:0]  wf_r;
  logic [63:0]  cyc_r;
  logic [31:0]  rate_r;
  logic [31:0]  freq_r;
  logic [31:0]  rt_r;
  logic [31:0]  rb_r;
  logic [23:0]  poll1000_r;
  logic [14:0]  mh_r;
  logic [31:0]  nt_r;
  logic [63:0]  prod_r;
  logic [95:0]  acc_r;
  logic [32:0]  rem_r;
  logic [32:0]  dvs_r;
  logic [31:0]  q_r;
  logic         ovf_r;
  logic [6:0]   cnt_r;
  logic         out_valid_r;
  glwa_pkg::out_t out_r;

  // Shared multiplier operand selection.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    unique case (state_r)
      S_BM0:   begin mul_a = cyc_r[31:0];  mul_b = glwa_pkg::MICROS_PER_S; end
      S_BM1:   begin mul_a = cyc_r[63:32]; mul_b = glwa_pkg::MICROS_PER_S; end
      S_SM:    begin mul_a = wb_r;         mul_b = nt_r;                   end
      S_FM0:   begin mul_a = wf_r;         mul_b = wt_r;                   end
      S_FM1:   begin mul_a = freq_r;       mul_b = rt_r;                   end
      default: begin mul_a = '0;           mul_b = '0;                     end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // One restoring divide step.
  logic [33:0] div_sh;
  logic        div_ge;
  logic [33:0] div_rem;
  logic [31:0] div_q;

  assign div_sh  = {rem_r, acc_r[95]};
  assign div_ge  = div_sh >= {1'b0, dvs_r};
  assign div_rem = div_ge ? (div_sh - {1'b0, dvs_r}) : div_sh;
  assign div_q   = ovf_r ? glwa_pkg::MAX32 : q_r;

  // Accept-time differences.
  logic [63:0] in_cyc;
  logic [63:0] in_dt;
  logic [31:0] in_rt;

  assign in_cyc = in_data.busy_cycle_count - last_busy_r;
  assign in_dt  = in_data.timestamp_us - last_time_r;
  assign in_rt  = (in_dt[63:32] != '0) ? glwa_pkg::MAX32 : in_dt[31:0];

  // Window sums and thresholds.
  logic [32:0] wsum;
  logic [32:0] bsum;
  logic [24:0] hist_us;
  logic [17:0] poll11;
  logic [36:0] hist_prod;
  logic        replace;

  assign wsum      = {1'b0, wt_r} + {1'b0, rt_r};
  assign bsum      = {1'b0, wb_r} + {1'b0, rb_r};
  assign hist_us   = mh_r * glwa_pkg::MICROS_PER_MS;
  assign poll11    = poll_r * glwa_pkg::HIST_NUM;
  // The hysteresis limit, period * 11 / 10, by reciprocal multiplication.
  assign hist_prod = poll11 * glwa_pkg::HIST_RECIP;
  assign replace   = ({8'b0, rt_r[31:0]} >= {16'b0, poll1000_r}) || (wt_r == '0);

  // A finished window moves to the output register once that register is free.
  logic push_fire;

  assign push_fire = (state_r == S_PUSH) && (!out_valid_r || out_ready);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dop_r       <= D_BUSY;
      poll_r      <= glwa_pkg::POLL_RESET;
      last_busy_r <= '0;
      last_time_r <= '0;
      wb_r        <= '0;
      wt_r        <= '0;
      wf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        poll_r <= cfg_wdata;
      end
      if (push_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.opcode == glwa_pkg::OP_RESUME) begin
              last_busy_r <= '0;
              last_time_r <= in_data.timestamp_us;
            end else begin
              cyc_r       <= in_cyc;
              rt_r        <= in_rt;
              rate_r      <= in_data.counter_rate_hz;
              freq_r      <= in_data.frequency_hz;
              poll1000_r  <= poll_r * glwa_pkg::MICROS_PER_MS;
              last_busy_r <= in_data.busy_cycle_count;
              last_time_r <= in_data.timestamp_us;
              state_r     <= S_BM0;
            end
          end
        end
        S_BM0: begin
          prod_r  <= mul_p;
          state_r <= S_BM1;
        end
        S_BM1: begin
          acc_r   <= {32'b0, prod_r};
          prod_r  <= mul_p;
          state_r <= S_BADD;
        end
        S_BADD: begin
          // Busy cycles times one million, then divide by the counter rate.
          acc_r   <= acc_r + {prod_r, 32'b0};
          dvs_r   <= {1'b0, rate_r};
          rem_r   <= '0;
          q_r     <= '0;
          ovf_r   <= 1'b0;
          cnt_r   <= 7'(glwa_pkg::DIV_STEPS);
          dop_r   <= D_BUSY;
          state_r <= S_DIV;
        end
        S_DIV: begin
          acc_r <= {acc_r[94:0], 1'b0};
          rem_r <= div_rem[32:0];
          q_r   <= {q_r[30:0], div_ge};
          ovf_r <= ovf_r | q_r[31];
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            state_r <= S_DIVDONE;
          end
        end
        S_DIVDONE: begin
          unique case (dop_r)
            D_BUSY: begin
              rb_r    <= div_q;
              mh_r    <= hist_prod[36:22];
              state_r <= S_DECIDE;
            end
            D_SCALE: begin
              wb_r    <= div_q;
              wt_r    <= nt_r;
              state_r <= S_FM0;
            end
            default: begin
              wf_r    <= div_q;
              wb_r    <= bsum[32] ? glwa_pkg::MAX32 : bsum[31:0];
              wt_r    <= wsum[32] ? glwa_pkg::MAX32 : wsum[31:0];
              state_r <= S_PUSH;
            end
          endcase
        end
        S_DECIDE: begin
          if (replace) begin
            wb_r    <= rb_r;
            wt_r    <= rt_r;
            wf_r    <= freq_r;
            state_r <= S_PUSH;
          end else if (wsum >= {8'b0, hist_us}) begin
            nt_r    <= {8'b0, poll1000_r} - rt_r;
            state_r <= S_SM;
          end else begin
            state_r <= S_FM0;
          end
        end
        S_SM: begin
          prod_r  <= mul_p;
          state_r <= S_SLOAD;
        end
        S_SLOAD: begin
          // Rescale old busy time to the shrunken window.
          acc_r   <= {32'b0, prod_r};
          dvs_r   <= {1'b0, wt_r};
          rem_r   <= '0;
          q_r     <= '0;
          ovf_r   <= 1'b0;
          cnt_r   <= 7'(glwa_pkg::DIV_STEPS);
          dop_r   <= D_SCALE;
          state_r <= S_DIV;
        end
        S_FM0: begin
          prod_r  <= mul_p;
          state_r <= S_FM1;
        end
        S_FM1: begin
          acc_r   <= {32'b0, prod_r};
          prod_r  <= mul_p;
          state_r <= S_FADD;
        end
        S_FADD: begin
          // Time-weighted frequency sum divided by total time.
          acc_r   <= acc_r + {32'b0, prod_r};
          dvs_r   <= wsum;
          rem_r   <= '0;
          q_r     <= '0;
          ovf_r   <= 1'b0;
          cnt_r   <= 7'(glwa_pkg::DIV_STEPS);
          dop_r   <= D_FREQ;
          state_r <= S_DIV;
        end
        default: begin
          // Hand the window to the output register once it is free.
          if (push_fire) begin
            out_r.avg_busy_us      <= wb_r;
            out_r.avg_total_us     <= wt_r;
            out_r.avg_frequency_hz <= wf_r;
            state_r                <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
